// ===== rtl/core/lvpd_pkg.sv =====
// Package: widths, codes and fixed-point limits for the limited velocity PI drive.
package lvpd_pkg;

    // Position sample width
    localparam int SAMPLE_BITS = 12;

    // Field and register widths
    localparam int POWER_W  = 16;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int DB_W     = 15;
    localparam int GAIN_W   = 16;
    localparam int Q14_W    = 17;
    localparam int SUM_W    = 32;
    localparam int MUL_A_W  = 33;
    localparam int PROD_W   = MUL_A_W + GAIN_W + 1;

    // Fixed-point limits
    localparam int Q14_MAX  = 65535;
    localparam int Q14_MIN  = -65536;
    localparam int VEL_LIM  = 32768;
    localparam int DRV_MAX  = 32767;
    localparam int DRV_MIN  = -32768;

    // Shift amounts
    localparam int CMD_SHIFT   = 13;
    localparam int VEL_SHIFT   = SAMPLE_BITS - 2;
    localparam int DRIVE_SHIFT = 11;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_JOYSTICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DIRECT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_UP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DOWN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN     = 3'd7;

    // Signed Q3.14 value type
    typedef logic signed [Q14_W-1:0] q14_t;

endpackage

// ===== rtl/core/lvpd_if.sv =====
// Interfaces: tick input channel and drive result channel.
interface lvpd_tick_if
    import lvpd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              command;
    logic signed [POWER_W-1:0]     power;
    logic [SAMPLE_BITS-1:0]        pot_sample;
    logic                          automation_active;

    modport source (output valid, command, power, pot_sample, automation_active,
                    input ready);
    modport sink   (input valid, command, power, pot_sample, automation_active,
                    output ready);
endinterface

interface lvpd_drive_if
    import lvpd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [POWER_W-1:0]     motor_drive;
    logic                          stopped_at_limit;

    modport source (output valid, motor_drive, stopped_at_limit, input ready);
    modport sink   (input valid, motor_drive, stopped_at_limit, output ready);
endinterface

// ===== rtl/core/limited_velocity_pi_drive.sv =====
// Top level: velocity-loop PI drive with travel limits on one shared multiplier.
// A move beat takes one sequencer step each for rate multiply, velocity multiply,
// error, two gain multiplies and final sum; the final sum holds while an older result waits.
// A new beat is taken only once the last one is back in idle; reset and ignored beats stay in idle.
// The result register frees the input side while a result waits.
// Reset loads register defaults and clears the error sum, previous sample and sequencer.
module limited_velocity_pi_drive
    import lvpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lvpd_tick_if.sink            tick,
    lvpd_drive_if.source         drive,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RATE = 3'd1;
    localparam logic [2:0] S_VEL  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_PROP = 3'd4;
    localparam logic [2:0] S_INT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // Configuration registers
    logic [DB_W-1:0]        deadband_reg, deadband_next;
    logic [SAMPLE_BITS-1:0] top_limit_reg, top_limit_next;
    logic [SAMPLE_BITS-1:0] bottom_limit_reg, bottom_limit_next;
    logic [GAIN_W-1:0]      rate_up_reg, rate_up_next;
    logic [GAIN_W-1:0]      rate_down_reg, rate_down_next;
    logic [GAIN_W-1:0]      vel_scale_reg, vel_scale_next;
    logic [GAIN_W-1:0]      prop_gain_reg, prop_gain_next;
    logic [GAIN_W-1:0]      int_gain_reg, int_gain_next;

    // Loop state and sequencer
    logic [2:0]                state_reg, state_next;
    logic [SAMPLE_BITS-1:0]    prev_reg, prev_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;

    // Working registers
    logic signed [Q14_W-1:0]   p_reg, p_next;
    logic [SAMPLE_BITS-1:0]    sample_reg, sample_next;
    logic                      stop_reg, stop_next;
    q14_t                      cmd_reg, cmd_next;
    q14_t                      err_reg, err_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [POWER_W-1:0] drv_reg, drv_next;
    logic                      stopped_reg, stopped_next;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // Datapath intermediates
    logic                      accept;
    logic signed [Q14_W-1:0]   p_in;
    logic signed [Q14_W-1:0]   p_neg;
    logic [Q14_W-1:0]          p_abs;
    logic                      go_up;
    logic                      go_down;
    logic                      stop_now;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [PROD_W-1:0]  cmd_sh;
    q14_t                      cmd_sat;
    logic signed [PROD_W:0]    vel_neg;
    logic signed [PROD_W:0]    vel_sh;
    q14_t                      vel;
    logic signed [Q14_W:0]     err_wide;
    q14_t                      err_sat;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [PROD_W:0]    drv_wide;
    logic signed [PROD_W:0]    drv_sh;
    logic signed [POWER_W-1:0] drv_sat;

    assign accept      = tick.valid && tick.ready;
    assign tick.ready  = (state_reg == S_IDLE);
    assign drive.valid = out_valid_reg;
    assign drive.motor_drive      = drv_reg;
    assign drive.stopped_at_limit = stopped_reg;

    // Multiply a signed operand by an unsigned gain
    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Form the request: negate and deadband joystick beats
    always_comb
    begin
        p_neg = -Q14_W'(tick.power);
        if (p_neg == Q14_W'(VEL_LIM))
        begin
            p_neg = Q14_W'(DRV_MAX);
        end
        p_abs = p_neg[Q14_W-1] ? Q14_W'(-p_neg) : Q14_W'(p_neg);
        if (tick.command == CMD_JOYSTICK)
        begin
            p_in = (p_abs <= Q14_W'(deadband_reg)) ? '0 : p_neg;
        end
        else
        begin
            p_in = Q14_W'(tick.power);
        end
    end

    // Check the travel limits
    assign go_up    = !p_reg[Q14_W-1] && (p_reg != '0);
    assign go_down  = p_reg[Q14_W-1];
    assign stop_now = (go_up && (sample_reg >= top_limit_reg))
                   || (go_down && (sample_reg <= bottom_limit_reg));
    assign diff     = $signed({1'b0, sample_reg}) - $signed({1'b0, prev_reg});

    // Scale, saturate and invert the velocity command
    always_comb
    begin
        cmd_sh = prod_reg >>> CMD_SHIFT;
        if (cmd_sh > PROD_W'(Q14_MAX))
        begin
            cmd_sat = Q14_W'(Q14_MIN + 1);
        end
        else if (cmd_sh <= PROD_W'(Q14_MIN))
        begin
            cmd_sat = Q14_W'(Q14_MAX);
        end
        else
        begin
            cmd_sat = -Q14_W'(cmd_sh);
        end
    end

    // Form the measured velocity, the error and the saturated error sum
    always_comb
    begin
        vel_neg = -(PROD_W + 1)'(prod_reg);
        vel_sh  = vel_neg >>> VEL_SHIFT;
        if (vel_sh > (PROD_W + 1)'(VEL_LIM))
        begin
            vel = Q14_W'(VEL_LIM);
        end
        else if (vel_sh < (PROD_W + 1)'(-VEL_LIM))
        begin
            vel = Q14_W'(-VEL_LIM);
        end
        else
        begin
            vel = Q14_W'(vel_sh);
        end
        err_wide = (Q14_W + 1)'(cmd_reg) - (Q14_W + 1)'(vel);
        if (err_wide > (Q14_W + 1)'(Q14_MAX))
        begin
            err_sat = Q14_W'(Q14_MAX);
        end
        else if (err_wide < (Q14_W + 1)'(Q14_MIN))
        begin
            err_sat = Q14_W'(Q14_MIN);
        end
        else
        begin
            err_sat = Q14_W'(err_wide);
        end
        sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(err_sat);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                      : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Sum the two gain terms and saturate the drive
    always_comb
    begin
        drv_wide = (PROD_W + 1)'(acc_reg) + (PROD_W + 1)'(prod_reg);
        drv_sh   = drv_wide >>> DRIVE_SHIFT;
        if (drv_sh > (PROD_W + 1)'(DRV_MAX))
        begin
            drv_sat = POWER_W'(DRV_MAX);
        end
        else if (drv_sh < (PROD_W + 1)'(DRV_MIN))
        begin
            drv_sat = POWER_W'(DRV_MIN);
        end
        else
        begin
            drv_sat = POWER_W'(drv_sh);
        end
    end

    // Sequence the shared multiplier and update state
    always_comb
    begin
        deadband_next     = deadband_reg;
        top_limit_next    = top_limit_reg;
        bottom_limit_next = bottom_limit_reg;
        rate_up_next      = rate_up_reg;
        rate_down_next    = rate_down_reg;
        vel_scale_next    = vel_scale_reg;
        prop_gain_next    = prop_gain_reg;
        int_gain_next     = int_gain_reg;
        state_next        = state_reg;
        prev_next         = prev_reg;
        sum_next          = sum_reg;
        out_valid_next    = out_valid_reg;
        p_next            = p_reg;
        sample_next       = sample_reg;
        stop_next         = stop_reg;
        cmd_next          = cmd_reg;
        err_next          = err_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        drv_next          = drv_reg;
        stopped_next      = stopped_reg;
        mul_a             = '0;
        mul_b             = '0;

        // Write a configuration register
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEADBAND:     deadband_next     = cfg_data[DB_W-1:0];
                REG_TOP_LIMIT:    top_limit_next    = cfg_data[SAMPLE_BITS-1:0];
                REG_BOTTOM_LIMIT: bottom_limit_next = cfg_data[SAMPLE_BITS-1:0];
                REG_RATE_UP:      rate_up_next      = cfg_data;
                REG_RATE_DOWN:    rate_down_next    = cfg_data;
                REG_VEL_SCALE:    vel_scale_next    = cfg_data;
                REG_PROP_GAIN:    prop_gain_next    = cfg_data;
                REG_INT_GAIN:     int_gain_next     = cfg_data;
                default:          deadband_next     = deadband_reg;
            endcase
        end

        // Drop the result once taken
        if (drive.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    p_next      = p_in;
                    sample_next = tick.pot_sample;
                    case (tick.command)
                        CMD_RESET:
                        begin
                            sum_next  = '0;
                            prev_next = tick.pot_sample;
                        end
                        CMD_JOYSTICK:
                        begin
                            if (!tick.automation_active)
                            begin
                                state_next = S_RATE;
                            end
                        end
                        CMD_DIRECT:
                        begin
                            state_next = S_RATE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RATE:
            begin
                mul_a      = stop_now ? '0 : MUL_A_W'(p_reg);
                mul_b      = go_up ? rate_up_reg : rate_down_reg;
                prod_next  = mul_p;
                stop_next  = stop_now;
                state_next = S_VEL;
            end
            S_VEL:
            begin
                cmd_next   = cmd_sat;
                mul_a      = MUL_A_W'(diff);
                mul_b      = vel_scale_reg;
                prod_next  = mul_p;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next   = err_sat;
                sum_next   = sum_sat;
                prev_next  = sample_reg;
                state_next = S_PROP;
            end
            S_PROP:
            begin
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = prop_gain_reg;
                acc_next   = mul_p;
                state_next = S_INT;
            end
            S_INT:
            begin
                mul_a      = MUL_A_W'(sum_reg);
                mul_b      = int_gain_reg;
                prod_next  = mul_p;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || drive.ready)
                begin
                    drv_next       = drv_sat;
                    stopped_next   = stop_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg     <= DB_W'(3277);
            top_limit_reg    <= {SAMPLE_BITS{1'b1}};
            bottom_limit_reg <= '0;
            rate_up_reg      <= GAIN_W'(4096);
            rate_down_reg    <= GAIN_W'(4096);
            vel_scale_reg    <= GAIN_W'(4096);
            prop_gain_reg    <= GAIN_W'(4096);
            int_gain_reg     <= GAIN_W'(410);
            state_reg        <= S_IDLE;
            prev_reg         <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            deadband_reg     <= deadband_next;
            top_limit_reg    <= top_limit_next;
            bottom_limit_reg <= bottom_limit_next;
            rate_up_reg      <= rate_up_next;
            rate_down_reg    <= rate_down_next;
            vel_scale_reg    <= vel_scale_next;
            prop_gain_reg    <= prop_gain_next;
            int_gain_reg     <= int_gain_next;
            state_reg        <= state_next;
            prev_reg         <= prev_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        sample_reg  <= sample_next;
        stop_reg    <= stop_next;
        cmd_reg     <= cmd_next;
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        drv_reg     <= drv_next;
        stopped_reg <= stopped_next;
    end

endmodule
